// ===== rtl/core/msu_pkg.sv =====
package msu_pkg;

   localparam int MARK_LEN = 8;

   // "==@FILE:"
   localparam logic [7:0] MARKER [MARK_LEN] = '{
      8'h3D, 8'h3D, 8'h40, 8'h46, 8'h49, 8'h4C, 8'h45, 8'h3A
   };

   localparam logic [7:0] CHAR_LF        = 8'd10;
   localparam logic [7:0] CHAR_PRINT_MIN = 8'd32;

   localparam int INDEX_W = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic CSR_IDX_NAME_LIMIT = 1'b0;
   localparam logic [7:0] NAME_LIMIT_RESET = 8'd255;

   typedef enum logic [1:0] {
      KIND_PAYLOAD    = 2'd0,
      KIND_NAME       = 2'd1,
      KIND_NAME_END   = 2'd2,
      KIND_STREAM_END = 2'd3
   } kind_type;

   // one classified input word, expanded by the back end into result words
   typedef struct packed {
      logic [INDEX_W-1:0] part_index;
      logic [2:0]         mark_cnt;
      logic               byte_en;
      logic               byte_is_name;
      logic [7:0]         byte_val;
      logic               name_end;
      logic               stream_end;
      logic [3:0]         word_cnt;
   } job_type;

   // true when marker[pos..k-1] equals marker[0..k-1-pos]
   function automatic logic prefix_shift_ok(input logic [2:0] k, input logic [2:0] pos);
      logic ok;
      int   i;
      int   j;
      ok = 1'b1;
      for (i = 0; i < MARK_LEN; i++) begin
         j = i + int'(pos);
         if (j < int'(k) && MARKER[j[2:0]] != MARKER[i[2:0]]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

// ===== rtl/core/msu_req_if.sv =====
interface msu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_end;

   modport source (output valid, output in_byte, output stream_end, input ready);
   modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

// ===== rtl/core/msu_rsp_if.sv =====
interface msu_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  out_byte;
   logic [15:0] part_index;
   logic        last;

   modport source (output valid, output kind, output out_byte, output part_index,
                   output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input part_index,
                   input last, output ready);
endinterface

// ===== rtl/core/msu_csr.sv =====
module msu_csr
   import msu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [7:0]            name_limit
);

   logic [7:0] limit_ff;
   logic [7:0] limit_in;
   logic       hit;

   assign pready = 1'b1;
   assign hit    = (paddr[2] == CSR_IDX_NAME_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && pready && hit) begin
         limit_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= NAME_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata     = hit ? {{(CSR_DATA_W-8){1'b0}}, limit_ff} : '0;
   assign name_limit = limit_ff;

endmodule

// ===== rtl/core/msu_front.sv =====
module msu_front
   import msu_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   msu_req_if.sink    req,
   input  logic [7:0] name_limit,
   output job_type    job,
   output logic       job_valid,
   input  logic       job_ready
);

   localparam int EXT_W = (COUNT_WIDTH > INDEX_W) ? COUNT_WIDTH : INDEX_W;

   logic                   name_mode_ff, name_mode_in;
   logic [2:0]             match_ff, match_in;
   logic [7:0]             len_ff, len_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic                   accept;
   logic                   found;
   logic                   full_match;
   logic [3:0]             pos_sel;
   logic [EXT_W-1:0]       count_ext;
   logic                   count_nz;

   assign req.ready = job_ready;
   assign accept    = req.valid && job_ready;
   assign count_ext = EXT_W'(count_ff);
   assign count_nz  = (count_ff != '0);

   // leftmost place where the held prefix plus the new word can still start a marker
   always_comb begin
      found   = 1'b0;
      pos_sel = {1'b0, match_ff} + 4'd1;
      for (int p = 0; p < MARK_LEN; p++) begin
         if (!found && (3'(p) <= match_ff) && prefix_shift_ok(match_ff, 3'(p)) &&
             (req.in_byte == MARKER[match_ff - 3'(p)])) begin
            found   = 1'b1;
            pos_sel = 4'(p);
         end
      end
      full_match = found && (pos_sel == 4'd0) && (match_ff == 3'd7);
   end

   always_comb begin
      job            = '0;
      job.part_index = count_ext[INDEX_W-1:0];
      job_valid      = 1'b0;
      name_mode_in   = name_mode_ff;
      match_in       = match_ff;
      len_in         = len_ff;
      count_in       = count_ff;

      if (req.stream_end) begin
         job.stream_end = 1'b1;
         if (name_mode_ff) begin
            job.name_end = 1'b1;
            job.word_cnt = 4'd2;
         end else begin
            job.mark_cnt = count_nz ? match_ff : 3'd0;
            job.word_cnt = {1'b0, job.mark_cnt} + 4'd1;
         end
         job_valid    = req.valid;
         name_mode_in = 1'b0;
         match_in     = '0;
         len_in       = '0;
         count_in     = '0;
      end else if (name_mode_ff) begin
         if (req.in_byte == CHAR_LF || len_ff >= name_limit) begin
            job.name_end = 1'b1;
            job.word_cnt = 4'd1;
            job_valid    = req.valid;
            name_mode_in = 1'b0;
            len_in       = '0;
         end else if (req.in_byte >= CHAR_PRINT_MIN) begin
            job.byte_en      = 1'b1;
            job.byte_is_name = 1'b1;
            job.byte_val     = req.in_byte;
            job.word_cnt     = 4'd1;
            job_valid        = req.valid;
            len_in           = len_ff + 8'd1;
         end
      end else if (full_match) begin
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
         name_mode_in = 1'b1;
         match_in     = '0;
         len_in       = '0;
      end else begin
         if (pos_sel > {1'b0, match_ff}) begin
            match_in     = '0;
            job.mark_cnt = match_ff;
            job.byte_en  = 1'b1;
         end else begin
            match_in     = 3'({1'b0, match_ff} + 4'd1 - pos_sel);
            job.mark_cnt = pos_sel[2:0];
         end
         job.byte_val = req.in_byte;
         job.word_cnt = {1'b0, job.mark_cnt} + {3'b000, job.byte_en};
         job_valid    = req.valid && count_nz && (job.word_cnt != 4'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_mode_ff <= 1'b0;
         match_ff     <= '0;
         len_ff       <= '0;
         count_ff     <= '0;
      end else if (accept) begin
         name_mode_ff <= name_mode_in;
         match_ff     <= match_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
      end
   end

   a_no_prefix_in_name: assert property (@(posedge clock) disable iff (reset)
      name_mode_ff |-> (match_ff == '0))
      else $error("marker prefix held while in name mode");

   a_len_clear_scan: assert property (@(posedge clock) disable iff (reset)
      !name_mode_ff |-> (len_ff == '0))
      else $error("name length not cleared while scanning");

   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> (job.word_cnt != 4'd0))
      else $error("empty job pushed to queue");

endmodule

// ===== rtl/core/msu_queue.sv =====
module msu_queue
   import msu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_data,
   output logic    push_ready,
   output logic    pop_valid,
   output job_type pop_data,
   input  logic    pop_ready
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH)) |->
      (QUEUE_PTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_PTR_W-1:0]))
      else $error("queue pointers disagree with fill count");

endmodule

// ===== rtl/core/msu_back.sv =====
module msu_back
   import msu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     job_valid,
   input  job_type  job,
   output logic     job_pop,
   msu_rsp_if.source rsp
);

   logic [3:0]         pos_ff, pos_in;
   logic               valid_ff, valid_in;
   kind_type           kind_ff, kind_in;
   logic [7:0]         byte_ff, byte_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               last_ff, last_in;

   logic               load;
   logic               word_last;
   logic [3:0]         rel;

   assign load      = job_valid && (!valid_ff || rsp.ready);
   assign word_last = (pos_ff == job.word_cnt - 4'd1);
   assign rel       = pos_ff - {1'b0, job.mark_cnt};
   assign job_pop   = load && word_last;

   // word order: held marker bytes, then the data word, then name end, then stream end
   always_comb begin
      kind_in  = KIND_STREAM_END;
      byte_in  = '0;
      index_in = job.part_index;
      last_in  = word_last;
      pos_in   = pos_ff;
      valid_in = valid_ff && !rsp.ready;

      if (pos_ff < {1'b0, job.mark_cnt}) begin
         kind_in = KIND_PAYLOAD;
         byte_in = MARKER[pos_ff[2:0]];
      end else begin
         case (rel)
            4'd0: begin
               if (job.byte_en) begin
                  kind_in = job.byte_is_name ? KIND_NAME : KIND_PAYLOAD;
                  byte_in = job.byte_val;
               end else if (job.name_end) begin
                  kind_in = KIND_NAME_END;
               end else begin
                  kind_in = KIND_STREAM_END;
               end
            end
            4'd1: begin
               if (job.byte_en && job.name_end) begin
                  kind_in = KIND_NAME_END;
               end else begin
                  kind_in = KIND_STREAM_END;
               end
            end
            default: begin
               kind_in = KIND_STREAM_END;
            end
         endcase
      end

      if (load) begin
         valid_in = 1'b1;
         pos_in   = word_last ? 4'd0 : pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         index_ff <= index_in;
         last_ff  <= last_in;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.kind       = kind_ff;
   assign rsp.out_byte   = byte_ff;
   assign rsp.part_index = index_ff;
   assign rsp.last       = last_ff;

   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (pos_ff == 4'd0))
      else $error("word position not restarted after last word");

   a_pos_in_job: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> (pos_ff < job.word_cnt))
      else $error("word position beyond job length");

endmodule

// ===== rtl/core/marker_delimited_stream_splitter_unit.sv =====
// Splits a byte stream into parts that each open with the marker "==@FILE:", followed by a
// name line; bytes before the first marker are dropped. The front end takes one word per
// cycle whenever its four-entry job queue has room, classifies it and updates the match
// state in that cycle; the back end turns each job into result words, one per cycle while
// the output is not stalled, from a registered output stage, so a result passes through
// the job queue and then the output register. A word causes at most eight results, and
// the queue lets the front keep taking words during such a burst until it fills.
// The name limit register sits at address 0 of the APB port and should be written while
// the block is idle.
module marker_delimited_stream_splitter_unit
   import msu_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   msu_req_if.sink               req_chan,
   msu_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [7:0] name_limit;
   job_type    push_job;
   logic       push_valid;
   logic       push_ready;
   job_type    head_job;
   logic       head_valid;
   logic       head_pop;

   msu_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .name_limit (name_limit)
   );

   msu_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .name_limit (name_limit),
      .job        (push_job),
      .job_valid  (push_valid),
      .job_ready  (push_ready)
   );

   msu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_job),
      .push_ready (push_ready),
      .pop_valid  (head_valid),
      .pop_data   (head_job),
      .pop_ready  (head_pop)
   );

   msu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (head_pop),
      .rsp       (rsp_chan)
   );

endmodule
